[hdl/todki_pkg.sv]
package todki_pkg;

	localparam int MAX_KEYFRAMES_DEF = 16;
	localparam int CHANNELS_DEF = 11;
	localparam int DAY_MINUTES = 1440;
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_SET = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	localparam logic [1:0] REG_MS_PER_MINUTE = 2'd0;
	localparam logic [1:0] REG_FREEZE = 2'd1;
	localparam logic [1:0] REG_ENTRY_COUNT = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN,
		ST_PDIV,
		ST_FSETUP,
		ST_FDIV,
		ST_RDA,
		ST_RDB,
		ST_MUL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

[hdl/time_of_day_keyframe_interpolator.sv]
// A tick runs a scan over the keyframes in use, then two divisions; the second is skipped when
// the bracket times are equal or the elapsed time or the interval is not positive. The results
// then follow one channel at a time through ST_RDA, ST_RDB, ST_MUL and ST_OUT. Set time and
// keyframe writes are taken in ST_IDLE. One item is handled at a time: the input is not ready
// until the last result of a tick has left. After reset a clearing pass zeroes all the
// MAX_KEYFRAMES*CHANNELS words of the channel memory. Reset is asynchronous, active low.
module time_of_day_keyframe_interpolator #(
	parameter int MAX_KEYFRAMES = todki_pkg::MAX_KEYFRAMES_DEF,
	parameter int CHANNELS = todki_pkg::CHANNELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] cmd,
	input logic [4:0] hour_in,
	input logic [5:0] minute_in,
	input logic [3:0] entry_index,
	input logic [3:0] field_select,
	input logic signed [15:0] word_value,
	output logic out_valid,
	input logic out_ready,
	output logic [3:0] channel,
	output logic signed [15:0] mixed_value,
	output logic [4:0] hour_out,
	output logic [5:0] minute_out,
	output logic last,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);

	localparam int KW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH = MAX_KEYFRAMES * CHANNELS;
	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(MAX_KEYFRAMES + 1);

	todki_pkg::state_t state_q, state_d;

	logic [15:0] ms_per_minute_q;
	logic freeze_q;
	logic [4:0] entry_count_q;
	logic [4:0] hour_q;
	logic [5:0] minute_q;
	logic [15:0] ms_progress_q;
	logic [10:0] kf_min_q [MAX_KEYFRAMES];
	logic [15:0] chan_mem [DEPTH];
	logic [15:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] clr_q;

	logic [KW:0] scan_q;
	logic [NW-1:0] count_eff;
	logic fi_ok_q, si_ok_q;
	logic [KW-1:0] fi_q, si_q, lo_q, hi_q;
	logic [10:0] fit_q, sit_q, lot_q, hit_q;
	logic [10:0] cur;
	logic [16:0] prog_q;
	logic signed [12:0] ftime_q;
	logic [CW-1:0] ch_q;
	logic signed [15:0] a_q;
	logic signed [16:0] diff_q;
	logic [16:0] frac_q;
	logic signed [34:0] prod_s1;
	logic signed [15:0] res_mix;

	logic div_start;
	logic [32:0] div_dvd;
	logic [15:0] div_dvs;
	logic [32:0] div_quo;
	logic div_busy;
	todki_pkg::div_ctl_t dctl;

	logic [15:0] per;
	logic in_acc, out_acc;
	logic [10:0] t_scan;
	logic [KW-1:0] scan_idx;
	logic signed [12:0] stime;
	logic signed [13:0] interval;
	logic signed [29:0] elapsed;
	logic do_mem_wr;
	logic [AW-1:0] wr_addr;
	logic [15:0] wr_data;

	assign per = (ms_per_minute_q == '0) ? 16'd1 : ms_per_minute_q;
	assign count_eff = (entry_count_q == '0) ? NW'(1) :
		((32'(entry_count_q) > MAX_KEYFRAMES) ? NW'(MAX_KEYFRAMES) : NW'(entry_count_q));
	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign in_ready = (state_q == todki_pkg::ST_IDLE);
	assign cur = 11'(hour_q) * 11'd60 + 11'(minute_q);
	assign scan_idx = scan_q[KW-1:0];
	assign t_scan = kf_min_q[scan_idx];

	assign stime = si_ok_q ? 13'(sit_q) : 13'(lot_q) + 13'(todki_pkg::DAY_MINUTES);
	assign interval = 14'(stime) - 14'(ftime_q);
	assign elapsed = {(14'(cur) - 14'(ftime_q)), 16'd0} + 30'(prog_q);

	assign dctl = {div_start, div_busy, !div_busy && !div_start};

	todki_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dctl.start),
		.dividend(div_dvd), .divisor(div_dvs), .quotient(div_quo), .busy(div_busy)
	);

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		div_dvd = {1'b0, ms_progress_q, 16'd0};
		div_dvs = per;
		rd_addr = AW'(32'(fi_q) * CHANNELS + 32'(ch_q));
		unique case (state_q)
			todki_pkg::ST_CLEAR: begin
				if (32'(clr_q) == DEPTH - 1) state_d = todki_pkg::ST_IDLE;
			end
			todki_pkg::ST_IDLE: begin
				if (in_acc && cmd == todki_pkg::CMD_TICK) state_d = todki_pkg::ST_SCAN;
			end
			todki_pkg::ST_SCAN: begin
				if (32'(scan_q) + 1 >= 32'(count_eff)) begin
					state_d = todki_pkg::ST_PDIV;
					div_start = 1'b1;
				end
			end
			todki_pkg::ST_PDIV: begin
				if (dctl.done) state_d = todki_pkg::ST_FSETUP;
			end
			todki_pkg::ST_FSETUP: begin
				if (ftime_q == 13'(stime) || elapsed <= 0 || interval <= 0) begin
					state_d = todki_pkg::ST_RDA;
				end else begin
					div_start = 1'b1;
					div_dvd = 33'(elapsed);
					div_dvs = 16'(interval);
					state_d = todki_pkg::ST_FDIV;
				end
			end
			todki_pkg::ST_FDIV: begin
				if (dctl.done) state_d = todki_pkg::ST_RDA;
			end
			todki_pkg::ST_RDA: state_d = todki_pkg::ST_RDB;
			todki_pkg::ST_RDB: begin
				rd_addr = AW'(32'(si_q) * CHANNELS + 32'(ch_q));
				state_d = todki_pkg::ST_MUL;
			end
			todki_pkg::ST_MUL: state_d = todki_pkg::ST_OUT;
			todki_pkg::ST_OUT: begin
				if (out_acc) begin
					state_d = (32'(ch_q) == CHANNELS - 1) ? todki_pkg::ST_IDLE
						: todki_pkg::ST_RDA;
				end
			end
			default: state_d = todki_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= todki_pkg::ST_CLEAR;
			clr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == todki_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_per_minute_q <= 16'd1000;
			freeze_q <= 1'b0;
			entry_count_q <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				todki_pkg::REG_MS_PER_MINUTE: ms_per_minute_q <= cfg_data;
				todki_pkg::REG_FREEZE: freeze_q <= cfg_data[0];
				todki_pkg::REG_ENTRY_COUNT: entry_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q <= '0;
			minute_q <= '0;
			ms_progress_q <= '0;
			for (int i = 0; i < MAX_KEYFRAMES; i++) kf_min_q[i] <= '0;
		end else if (in_acc) begin
			unique case (cmd)
				todki_pkg::CMD_TICK: begin
					if (!freeze_q) begin
						if (ms_progress_q + 16'd1 >= per) begin
							ms_progress_q <= '0;
							if (minute_q >= 6'd59) begin
								minute_q <= '0;
								hour_q <= (hour_q >= 5'd23) ? 5'd0 : hour_q + 5'd1;
							end else begin
								minute_q <= minute_q + 6'd1;
							end
						end else begin
							ms_progress_q <= ms_progress_q + 16'd1;
						end
					end
				end
				todki_pkg::CMD_SET: begin
					if (hour_in <= 5'd23 && minute_in <= 6'd59) begin
						hour_q <= hour_in;
						minute_q <= minute_in;
					end
				end
				todki_pkg::CMD_WRITE: begin
					if (32'(entry_index) < MAX_KEYFRAMES && field_select == '0)
						kf_min_q[KW'(entry_index)] <= word_value[10:0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		do_mem_wr = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		if (state_q == todki_pkg::ST_CLEAR) begin
			do_mem_wr = 1'b1;
		end else if (in_acc && cmd == todki_pkg::CMD_WRITE && 32'(entry_index) < MAX_KEYFRAMES
			&& field_select != '0 && 32'(field_select) <= CHANNELS) begin
			do_mem_wr = 1'b1;
			wr_addr = AW'(32'(entry_index) * CHANNELS + 32'(field_select) - 1);
			wr_data = word_value;
		end
	end

	always_ff @(posedge clk) begin
		if (do_mem_wr) chan_mem[wr_addr] <= wr_data;
		rd_q <= chan_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			todki_pkg::ST_IDLE: begin
				scan_q <= '0;
				fi_ok_q <= 1'b0;
				si_ok_q <= 1'b0;
				ch_q <= '0;
			end
			todki_pkg::ST_SCAN: begin
				scan_q <= scan_q + (KW+1)'(1);
				if (t_scan <= cur && (!fi_ok_q || t_scan > fit_q)) begin
					fi_ok_q <= 1'b1; fi_q <= scan_idx; fit_q <= t_scan;
				end
				if (t_scan >= cur && (!si_ok_q || t_scan < sit_q)) begin
					si_ok_q <= 1'b1; si_q <= scan_idx; sit_q <= t_scan;
				end
				if (scan_q == '0 || t_scan > hit_q) begin
					hi_q <= scan_idx; hit_q <= t_scan;
				end
				if (scan_q == '0 || t_scan < lot_q) begin
					lo_q <= scan_idx; lot_q <= t_scan;
				end
			end
			todki_pkg::ST_PDIV: begin
				if (!fi_ok_q) fi_q <= hi_q;
				ftime_q <= fi_ok_q ? 13'(fit_q) : 13'(hit_q) - 13'(todki_pkg::DAY_MINUTES);
				if (dctl.done) begin
					if (!si_ok_q) si_q <= lo_q;
					prog_q <= (div_quo > 33'(todki_pkg::ONE_Q16)) ? todki_pkg::ONE_Q16
						: div_quo[16:0];
				end
			end
			todki_pkg::ST_FSETUP: begin
				if (ftime_q == 13'(stime)) frac_q <= todki_pkg::ONE_Q16;
				else frac_q <= '0;
			end
			todki_pkg::ST_FDIV: begin
				if (dctl.done) frac_q <= (div_quo > 33'(todki_pkg::ONE_Q16))
					? todki_pkg::ONE_Q16 : div_quo[16:0];
			end
			todki_pkg::ST_RDB: a_q <= rd_q;
			todki_pkg::ST_MUL: begin
				diff_q <= 17'(signed'(rd_q)) - 17'(a_q);
			end
			todki_pkg::ST_OUT: begin
				if (out_acc) ch_q <= ch_q + CW'(1);
			end
			default: ;
		endcase
	end

	// The product is registered after the state enters ST_OUT; out_valid waits for it.
	logic prod_v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_q <= 1'b0;
		end else begin
			prod_v_q <= (state_q == todki_pkg::ST_OUT) && !out_acc;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= diff_q * signed'({1'b0, frac_q});
	end

	assign res_mix = a_q + 16'(prod_s1 >>> 16);

	assign out_valid = (state_q == todki_pkg::ST_OUT) && prod_v_q;
	assign channel = 4'(ch_q);
	assign mixed_value = res_mix;
	assign hour_out = hour_q;
	assign minute_out = minute_q;
	assign last = (32'(ch_q) == CHANNELS - 1);

endmodule

[hdl/todki_div.sv]
module todki_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [32:0] dividend,
	input logic [15:0] divisor,
	output logic [32:0] quotient,
	output logic busy
);

	logic [32:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] dvs_q;
	logic [5:0] cnt_q;
	logic [17:0] trial;
	logic [16:0] shifted;

	assign shifted = {rem_q[15:0], quo_q[32]};
	assign trial = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd33;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[17]) begin
				rem_q <= trial[16:0];
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[31:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign busy = (cnt_q != '0);

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int NUM_KF = 16;
	localparam int NUM_CH = 11;
	localparam int SETTLE_CYCLES = 300;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic [3:0] channel;
		logic signed [15:0] mixed_value;
		logic [4:0] hour_out;
		logic [5:0] minute_out;
		logic last;
	} mix_result_t;

	class mix_scoreboard;
		logic [15:0] ms_per_minute;
		logic freeze;
		logic [4:0] entry_count;
		logic [10:0] kf_minutes[NUM_KF];
		logic signed [15:0] kf_values[NUM_KF][NUM_CH];
		logic [4:0] hour;
		logic [5:0] minute;
		logic [15:0] progress;
		mix_result_t mixes_due[$];
		int errors;

		function new();
			ms_per_minute = 16'd1000;
			freeze = 1'b0;
			entry_count = 5'd1;
			hour = '0;
			minute = '0;
			progress = '0;
			errors = 0;
			foreach (kf_minutes[i]) begin
				kf_minutes[i] = '0;
				foreach (kf_values[i][k]) kf_values[i][k] = '0;
			end
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] value);
			case (idx)
				todki_pkg::REG_MS_PER_MINUTE: ms_per_minute = value;
				todki_pkg::REG_FREEZE: freeze = value[0];
				todki_pkg::REG_ENTRY_COUNT: entry_count = value[4:0];
				default: ;
			endcase
		endfunction

		function void predict_tick();
			longint per, count, cur, t, f_time, s_time, prog, frac, elapsed, interval, a, b, v;
			int fi, si, lo, hi;
			mix_result_t r;
			per = (ms_per_minute == 0) ? 1 : ms_per_minute;
			count = entry_count;
			fi = -1;
			si = -1;
			lo = 0;
			hi = 0;
			if (!freeze) begin
				progress = progress + 16'd1;
				if (progress >= per) begin
					progress = '0;
					minute = minute + 6'd1;
					if (minute >= 60) begin
						minute = '0;
						hour = hour + 5'd1;
					end
					if (hour >= 24) hour = '0;
				end
			end
			if (count == 0) count = 1;
			if (count > NUM_KF) count = NUM_KF;
			cur = hour * 60 + minute;
			for (int i = 0; i < count; i++) begin
				t = kf_minutes[i];
				if (t <= cur && (fi < 0 || t > kf_minutes[fi])) fi = i;
				if (t >= cur && (si < 0 || t < kf_minutes[si])) si = i;
				if (t > kf_minutes[hi]) hi = i;
				if (t < kf_minutes[lo]) lo = i;
			end
			if (fi < 0) begin
				fi = hi;
				f_time = longint'(kf_minutes[fi]) - todki_pkg::DAY_MINUTES;
			end else begin
				f_time = kf_minutes[fi];
			end
			if (si < 0) begin
				si = lo;
				s_time = longint'(kf_minutes[si]) + todki_pkg::DAY_MINUTES;
			end else begin
				s_time = kf_minutes[si];
			end
			prog = (longint'(progress) << 16) / per;
			if (prog > 65536) prog = 65536;
			if (f_time == s_time) begin
				frac = 65536;
			end else begin
				elapsed = (cur - f_time) * 65536 + prog;
				interval = s_time - f_time;
				if (elapsed <= 0 || interval <= 0) frac = 0;
				else frac = elapsed / interval;
				if (frac > 65536) frac = 65536;
			end
			for (int k = 0; k < NUM_CH; k++) begin
				a = kf_values[fi][k];
				b = kf_values[si][k];
				v = a + (((b - a) * frac) >>> 16);
				r.channel = 4'(k);
				r.mixed_value = v[15:0];
				r.hour_out = hour;
				r.minute_out = minute;
				r.last = (k == NUM_CH - 1);
				mixes_due = {mixes_due, r};
			end
		endfunction

		function void note_item(logic [1:0] c, logic [4:0] h, logic [5:0] m, logic [3:0] idx,
				logic [3:0] sel, logic [15:0] word);
			if (c == todki_pkg::CMD_TICK) begin
				predict_tick();
			end else if (c == todki_pkg::CMD_SET) begin
				if (h <= 23 && m <= 59) begin
					hour = h;
					minute = m;
				end
			end else if (c == todki_pkg::CMD_WRITE) begin
				if (sel == 0) kf_minutes[idx] = word[10:0];
				else if (sel <= NUM_CH) kf_values[idx][sel - 1] = word;
			end
		endfunction

		function void check_result(mix_result_t got);
			mix_result_t want;
			if (mixes_due.size() == 0) begin
				$display("%0t: unexpected result channel %0d value %0d", $time, got.channel,
					got.mixed_value);
				errors++;
				return;
			end
			want = mixes_due.pop_front();
			if (got.channel !== want.channel) begin
				$display("%0t: channel expected %0d actual %0d", $time, want.channel, got.channel);
				errors++;
			end
			if (got.mixed_value !== want.mixed_value) begin
				$display("%0t: mixed_value ch %0d expected %0d actual %0d", $time, want.channel,
					want.mixed_value, got.mixed_value);
				errors++;
			end
			if (got.hour_out !== want.hour_out) begin
				$display("%0t: hour_out expected %0d actual %0d", $time, want.hour_out,
					got.hour_out);
				errors++;
			end
			if (got.minute_out !== want.minute_out) begin
				$display("%0t: minute_out expected %0d actual %0d", $time, want.minute_out,
					got.minute_out);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = '0;
	logic [4:0] hour_in = '0;
	logic [5:0] minute_in = '0;
	logic [3:0] entry_index = '0;
	logic [3:0] field_select = '0;
	logic signed [15:0] word_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] channel;
	logic signed [15:0] mixed_value;
	logic [4:0] hour_out;
	logic [5:0] minute_out;
	logic last;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	mix_scoreboard sb = new();
	int cycles = 0;
	bit hold_request = 1'b0;
	int burst_left = 0;

	time_of_day_keyframe_interpolator dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		mix_result_t r;
		if (arst_n && in_valid && in_ready)
			sb.note_item(cmd, hour_in, minute_in, entry_index, field_select, word_value);
		if (arst_n && out_valid && out_ready) begin
			r.channel = channel;
			r.mixed_value = mixed_value;
			r.hour_out = hour_out;
			r.minute_out = minute_out;
			r.last = last;
			sb.check_result(r);
		end
	end

	initial begin
		int mode;
		mode = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (800) @(posedge clk);
				hold_request = 1'b0;
			end
			if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= cycles[2];
			endcase
		end
	end

	task automatic send_item(logic [1:0] c, logic [4:0] h, logic [5:0] m, logic [3:0] idx,
			logic [3:0] sel, logic [15:0] word);
		cmd <= c;
		hour_in <= h;
		minute_in <= m;
		entry_index <= idx;
		field_select <= sel;
		word_value <= word;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (sb.mixes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		sb.write_reg(idx, value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random();
		int pick;
		logic [4:0] h;
		logic [5:0] m;
		logic [3:0] sel;
		logic [15:0] word;
		pick = $urandom_range(0, 99);
		h = 5'($urandom);
		m = 6'($urandom);
		sel = 4'($urandom);
		word = 16'($urandom);
		if (pick < 55) begin
			send_item(todki_pkg::CMD_TICK, h, m, 4'($urandom), sel, word);
		end else if (pick < 70) begin
			if ($urandom_range(0, 4) != 0) begin
				h = 5'($urandom_range(0, 23));
				m = 6'($urandom_range(0, 59));
			end
			send_item(todki_pkg::CMD_SET, h, m, 4'($urandom), sel, word);
		end else if (pick < 97) begin
			if ($urandom_range(0, 5) != 0) sel = 4'($urandom_range(0, NUM_CH));
			if (sel == 0 && $urandom_range(0, 7) != 0) word = 16'($urandom_range(0, 1439));
			send_item(todki_pkg::CMD_WRITE, h, m, 4'($urandom), sel, word);
		end else begin
			send_item(CMD_UNUSED, h, m, 4'($urandom), sel, word);
		end
	endtask

	initial begin
		logic [15:0] ms_set[6] = '{16'd1, 16'd65535, 16'd3, 16'd0, 16'd7, 16'd2};
		logic [15:0] freeze_set[6] = '{16'd0, 16'd0, 16'd1, 16'd0, 16'd1, 16'd0};
		logic [15:0] count_set[6] = '{16'd16, 16'd5, 16'd16, 16'd0, 16'd31, 16'd2};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(todki_pkg::REG_MS_PER_MINUTE, 16'd2);
		write_reg(todki_pkg::REG_ENTRY_COUNT, 16'd2);
		send_item(todki_pkg::CMD_WRITE, 5'd0, 6'd0, 4'd0, 4'd0, 16'd360);
		send_item(todki_pkg::CMD_WRITE, 5'd0, 6'd0, 4'd1, 4'd0, 16'd1080);
		send_item(todki_pkg::CMD_WRITE, 5'd0, 6'd0, 4'd0, 4'd1, 16'h7FFF);
		send_item(todki_pkg::CMD_WRITE, 5'd0, 6'd0, 4'd1, 4'd1, 16'h8000);
		send_item(todki_pkg::CMD_WRITE, 5'd0, 6'd0, 4'd0, 4'd11, 16'h8000);
		send_item(todki_pkg::CMD_WRITE, 5'd0, 6'd0, 4'd1, 4'd11, 16'h7FFF);
		send_item(todki_pkg::CMD_WRITE, 5'd0, 6'd0, 4'd15, 4'd12, 16'h1234);
		send_item(todki_pkg::CMD_WRITE, 5'd0, 6'd0, 4'd15, 4'd15, 16'hFFFF);
		send_item(todki_pkg::CMD_TICK, 5'd0, 6'd0, 4'd0, 4'd0, 16'd0);
		send_item(todki_pkg::CMD_SET, 5'd12, 6'd0, 4'd0, 4'd0, 16'd0);
		send_item(todki_pkg::CMD_TICK, 5'd0, 6'd0, 4'd0, 4'd0, 16'd0);
		send_item(todki_pkg::CMD_TICK, 5'd0, 6'd0, 4'd0, 4'd0, 16'd0);
		send_item(todki_pkg::CMD_SET, 5'd31, 6'd10, 4'd0, 4'd0, 16'd0);
		send_item(todki_pkg::CMD_SET, 5'd3, 6'd63, 4'd0, 4'd0, 16'd0);
		send_item(todki_pkg::CMD_SET, 5'd23, 6'd59, 4'd0, 4'd0, 16'd0);
		send_item(todki_pkg::CMD_TICK, 5'd0, 6'd0, 4'd0, 4'd0, 16'd0);
		send_item(todki_pkg::CMD_TICK, 5'd0, 6'd0, 4'd0, 4'd0, 16'd0);
		send_item(todki_pkg::CMD_SET, 5'd6, 6'd0, 4'd0, 4'd0, 16'd0);
		send_item(todki_pkg::CMD_TICK, 5'd31, 6'd63, 4'd15, 4'd15, 16'hFFFF);
		send_item(CMD_UNUSED, 5'd1, 6'd1, 4'd1, 4'd1, 16'd1);
		send_item(todki_pkg::CMD_WRITE, 5'd0, 6'd0, 4'd1, 4'd0, 16'hFFFF);
		send_item(todki_pkg::CMD_TICK, 5'd0, 6'd0, 4'd0, 4'd0, 16'd0);
		send_item(todki_pkg::CMD_WRITE, 5'd0, 6'd0, 4'd1, 4'd0, 16'd360);
		send_item(todki_pkg::CMD_TICK, 5'd0, 6'd0, 4'd0, 4'd0, 16'd0);

		for (int p = 0; p < 6; p++) begin
			write_reg(todki_pkg::REG_MS_PER_MINUTE, ms_set[p]);
			write_reg(todki_pkg::REG_FREEZE, freeze_set[p]);
			write_reg(todki_pkg::REG_ENTRY_COUNT, count_set[p]);
			if (p == 1) hold_request = 1'b1;
			repeat (23) send_random();
		end
		in_valid <= 1'b0;

		while (sb.mixes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.mixes_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
